@@ hw/rtl/ptet_pkg.sv @@
// ----------------------------------------------------------------------------
// ptet_pkg
// Shared types, codes and sizes for the periodic tick event table.
// ----------------------------------------------------------------------------
package ptet_pkg;

	localparam int SLOTS_DEFAULT = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int DW            = 32;
	localparam int NFW           = $clog2(MAX_RESULTS + 1);

	// command codes
	localparam logic [1:0] CMD_REG   = 2'd0;
	localparam logic [1:0] CMD_UNREG = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NULL  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NOID  = 2'd3;

	typedef struct packed {
		logic [1:0]    command;
		logic [DW-1:0] handler_tag;
		logic [DW-1:0] period;
		logic [7:0]    slot;
	} in_item_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [2:0]    assigned_slot;
		logic [DW-1:0] fired_tag;
		logic          fired;
		logic          last;
	} out_item_t;

	typedef enum logic [1:0] {
		PK_STATUS,
		PK_MID,
		PK_LAST,
		PK_NOFIRE
	} push_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       idx_clr;
		logic       idx_inc;
		logic       tick_inc;
		logic       slot_set;
		logic       slot_clr;
		logic       rd;
		logic       div_start;
		logic       pend_clr;
		logic       pend_load;
		logic       res_set;
		logic [1:0] res_status;
		logic       res_slot_idx;
		logic       push;
		push_kind_t push_kind;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] command;
		logic       tag_zero;
		logic       sel_bad;
		logic       idx_end;
		logic       idx_en;
		logic       fire_max;
		logic       per_zero;
		logic       div_done;
		logic       rem_zero;
		logic       pend_valid;
		logic       out_free;
	} dp_sts_t;

endpackage

@@ hw/rtl/ptet_rem.sv @@
// ----------------------------------------------------------------------------
// ptet_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptet_rem
	import ptet_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);

	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;

	logic [DW:0]     trial;
	logic [DW+1:0]   diff;
	logic [DW-1:0]   rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[DW-1]};
		diff     = {1'b0, trial} - {2'b00, divisor};
		// no borrow means trial >= divisor
		rem_next = diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(DW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ hw/rtl/ptet_dp.sv @@
// ----------------------------------------------------------------------------
// ptet_dp
// Datapath: slot table, tick count, scan index, pending firing and output
// register.
// ----------------------------------------------------------------------------
module ptet_dp
	import ptet_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
)(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	in_item_t       in_q;
	logic [SLOTS-1:0] en_q;
	logic [DW-1:0]  tick_q;
	logic [CW-1:0]  idx_q;
	logic [NFW-1:0] nfire_q;
	logic           pend_valid_q;
	logic [2:0]     pend_slot_q;
	logic [DW-1:0]  pend_tag_q;
	logic [1:0]     res_status_q;
	logic [2:0]     res_slot_q;
	logic           out_valid_q;
	out_item_t      out_q;

	logic [DW-1:0]  tag_mem [SLOTS];
	logic [DW-1:0]  per_mem [SLOTS];
	logic [DW-1:0]  rd_tag_q;
	logic [DW-1:0]  rd_per_q;

	logic [IW-1:0]  idx;
	logic [2:0]     idx_slot;
	logic           div_done;
	logic [DW-1:0]  rem;
	out_item_t      push_item;

	assign idx      = idx_q[IW-1:0];
	assign idx_slot = 3'(idx_q);

	ptet_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tick_q),
		.divisor  (rd_per_q),
		.done     (div_done),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= '0;
			tick_q       <= '0;
			idx_q        <= '0;
			nfire_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.tick_inc)
				tick_q <= tick_q + 1'b1;
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.slot_set)
				en_q[idx] <= 1'b1;
			if (cmd.slot_clr)
				en_q[in_q.slot[IW-1:0]] <= 1'b0;
			if (cmd.pend_clr) begin
				pend_valid_q <= 1'b0;
				nfire_q      <= '0;
			end else if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
				nfire_q      <= nfire_q + 1'b1;
			end
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			in_q <= in_item;
		if (cmd.slot_set) begin
			tag_mem[idx] <= in_q.handler_tag;
			per_mem[idx] <= in_q.period;
		end
		if (cmd.rd) begin
			rd_tag_q <= tag_mem[idx];
			rd_per_q <= per_mem[idx];
		end
		if (cmd.pend_load) begin
			pend_slot_q <= idx_slot;
			pend_tag_q  <= rd_tag_q;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_slot_q   <= cmd.res_slot_idx ? idx_slot : 3'd0;
		end
		if (cmd.push)
			out_q <= push_item;
	end

	always_comb begin
		case (cmd.push_kind)
			PK_STATUS: push_item = '{res_status_q, res_slot_q, '0, 1'b0, 1'b1};
			PK_MID:    push_item = '{ST_OK, pend_slot_q, pend_tag_q, 1'b1, 1'b0};
			PK_LAST:   push_item = '{ST_OK, pend_slot_q, pend_tag_q, 1'b1, 1'b1};
			default:   push_item = '{ST_OK, 3'd0, '0, 1'b0, 1'b1};
		endcase
	end

	always_comb begin
		sts.command    = in_q.command;
		sts.tag_zero   = (in_q.handler_tag == '0);
		// range test first so an out-of-range slot never picks an enable bit
		sts.sel_bad    = (in_q.slot >= 8'(SLOTS)) || !en_q[in_q.slot[IW-1:0]];
		sts.idx_end    = (idx_q == CW'(SLOTS));
		sts.idx_en     = en_q[idx];
		sts.fire_max   = (nfire_q == NFW'(MAX_RESULTS));
		sts.per_zero   = (rd_per_q == '0);
		sts.div_done   = div_done;
		sts.rem_zero   = (rem == '0);
		sts.pend_valid = pend_valid_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ hw/rtl/ptet_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptet_ctrl
// Controller: decodes a transaction and sequences the slot scan.
// ----------------------------------------------------------------------------
module ptet_ctrl
	import ptet_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DECODE   = 9'b000000010,
		S_REG_SCAN = 9'b000000100,
		S_FINAL    = 9'b000001000,
		S_TK_CHECK = 9'b000010000,
		S_TK_LOAD  = 9'b000100000,
		S_TK_DIV   = 9'b001000000,
		S_TK_FIRE  = 9'b010000000,
		S_TK_END   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.push_kind = PK_STATUS;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.command)
					CMD_REG: begin
						if (sts.tag_zero) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_NULL;
							state_d        = S_FINAL;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_REG_SCAN;
						end
					end
					CMD_UNREG: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = sts.sel_bad ? ST_NOID : ST_OK;
						cmd.slot_clr   = !sts.sel_bad;
						state_d        = S_FINAL;
					end
					CMD_TICK: begin
						cmd.tick_inc = 1'b1;
						cmd.idx_clr  = 1'b1;
						cmd.pend_clr = 1'b1;
						state_d      = S_TK_CHECK;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_REG_SCAN: begin
				if (sts.idx_end) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_FULL;
					state_d        = S_FINAL;
				end else if (!sts.idx_en) begin
					cmd.slot_set     = 1'b1;
					cmd.res_set      = 1'b1;
					cmd.res_status   = ST_OK;
					cmd.res_slot_idx = 1'b1;
					state_d          = S_FINAL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = PK_STATUS;
					state_d       = S_IDLE;
				end
			end
			S_TK_CHECK: begin
				if (sts.idx_end || sts.fire_max) begin
					state_d = S_TK_END;
				end else if (!sts.idx_en) begin
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_TK_LOAD;
				end
			end
			S_TK_LOAD: begin
				if (sts.per_zero) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_TK_CHECK;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_TK_DIV;
				end
			end
			S_TK_DIV: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						state_d = S_TK_FIRE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_TK_CHECK;
					end
				end
			end
			S_TK_FIRE: begin
				// a newer firing means the held one is not the last
				if (!sts.pend_valid || sts.out_free) begin
					cmd.push      = sts.pend_valid;
					cmd.push_kind = PK_MID;
					cmd.pend_load = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = S_TK_CHECK;
				end
			end
			S_TK_END: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = sts.pend_valid ? PK_LAST : PK_NOFIRE;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/periodic_tick_event_table_unit.sv @@
// ----------------------------------------------------------------------------
// periodic_tick_event_table_unit
// Periodic event slot table with register, unregister and tick commands.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_ready is high only while the
// controller is idle, and a finished result may still wait in the output
// register while the next transaction is taken. Register scans the slots
// in order up to the first free one; unregister needs no scan. A tick walks
// every slot, skips disabled slots and runs the bit-serial 32-step remainder
// unit on each enabled slot with a nonzero period. Output backpressure can
// stall any of these commands. Up to MAX_RESULTS firings are reported per
// tick, in slot order.
// ----------------------------------------------------------------------------
module periodic_tick_event_table_unit
	import ptet_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ptet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptet_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
